/* src/mwac_pkg.sv */
// ----------------------------------------------------------------------------
// mwac_pkg: shared types and constants for the multiword add-carry generator
// Holds the word types, operation codes and the fixed per-word seed bases.
// ----------------------------------------------------------------------------
package mwac_pkg;

   localparam int unsigned WORD_WIDTH = 32;

   typedef logic [WORD_WIDTH-1:0] word_type;

   // word 0 most significant, word 5 least significant
   typedef logic [0:5][WORD_WIDTH-1:0] state_type;

   typedef logic [1:0] op_type;
   typedef logic [2:0] index_type;

   localparam op_type OP_DRAW  = 2'd0;
   localparam op_type OP_SEED  = 2'd1;
   localparam op_type OP_WRITE = 2'd2;
   localparam op_type OP_READ  = 2'd3;

   localparam index_type WORD_COUNT = 3'd6;

   localparam state_type SEED_BASE = {
      32'hF22D0E56, 32'h883126E9, 32'hC624DD2F,
      32'h0702C49C, 32'h9E353F7D, 32'h6FDF3B64
   };

endpackage

/* src/multiword_add_carry_rng_core.sv */
// ----------------------------------------------------------------------------
// multiword_add_carry_rng_core: six-word add-with-carry random generator
// Draw, seed, word write and word read over a 192-bit state, one word out
// for every word in.
// ----------------------------------------------------------------------------
//  channel  | direction | ports
//  req_     | in        | req_valid, req_ready, req_operation, req_data_value,
//           |           | req_word_index
//  rsp_     | out       | rsp_valid, rsp_ready, rsp_result_word
//
//  one request word in per cycle while the response register can take it;
//  its response is registered and shows in the cycle after acceptance. the
//  state update is a combinational chain of five 32-bit adds and the 192-bit
//  increment, so requests run back to back. reset loads the fixed seed bases
//  and empties the response register. a stalled response register holds
//  requests off only while it is full and not being taken.
// ----------------------------------------------------------------------------
module multiword_add_carry_rng_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mwac_pkg::op_type     req_operation,
   input  mwac_pkg::word_type   req_data_value,
   input  mwac_pkg::index_type  req_word_index,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mwac_pkg::word_type   rsp_result_word
);

   mwac_pkg::state_type state_ff;
   mwac_pkg::state_type state_in;
   mwac_pkg::state_type draw_state;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   mwac_pkg::word_type  rsp_word_ff;
   mwac_pkg::word_type  rsp_word_in;
   mwac_pkg::word_type  draw_result;
   logic                req_accept;

   logic [32:0]         sum4;
   mwac_pkg::word_type  n4, n3, n2, n1, n0;
   logic                c4, c3, c2, c1;
   logic                z5, z4, z3, z2, z1;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_word = rsp_word_ff;

   // add chain from the low words upward
   always_comb begin
      sum4 = {1'b0, state_ff[5]} + {1'b0, state_ff[4]};
      n4   = sum4[31:0];
      c4   = sum4[32];
      n3   = n4 + state_ff[3] + {31'd0, c4};
      c3   = (n3 < n4);
      n2   = n3 + state_ff[2] + {31'd0, c3};
      c2   = (n2 < n3);
      n1   = n2 + state_ff[1] + {31'd0, c2};
      c1   = (n1 < n2);
      n0   = n1 + state_ff[0] + {31'd0, c1};

      // 192-bit increment ripple
      z5 = &state_ff[5];
      z4 = z5 && (&n4);
      z3 = z4 && (&n3);
      z2 = z3 && (&n2);
      z1 = z2 && (&n1);

      draw_state[5] = state_ff[5] + 32'd1;
      draw_state[4] = n4 + {31'd0, z5};
      draw_state[3] = n3 + {31'd0, z4};
      draw_state[2] = n2 + {31'd0, z3};
      draw_state[1] = n1 + {31'd0, z2};
      draw_state[0] = n0 + {31'd0, z1};
      draw_result   = n0 + {31'd0, z1};
   end

   always_comb begin
      state_in    = state_ff;
      rsp_word_in = '0;
      case (req_operation)
         mwac_pkg::OP_DRAW: begin
            state_in    = draw_state;
            rsp_word_in = draw_result;
         end
         mwac_pkg::OP_SEED: begin
            for (int i = 0; i < 6; i++) begin
               state_in[i] = req_data_value + mwac_pkg::SEED_BASE[i];
            end
         end
         mwac_pkg::OP_WRITE: begin
            if (req_word_index < mwac_pkg::WORD_COUNT) begin
               state_in[req_word_index] = req_data_value;
            end
         end
         mwac_pkg::OP_READ: begin
            if (req_word_index < mwac_pkg::WORD_COUNT) begin
               rsp_word_in = state_ff[req_word_index];
            end
         end
         default: begin
            rsp_word_in = '0;
         end
      endcase
   end

   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mwac_pkg::SEED_BASE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

`ifndef SYNTH
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(state_ff))
      else $error("state changed without an accepted word");

   a_draw_low_inc: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_operation == mwac_pkg::OP_DRAW
      |=> state_ff[5] == $past(state_ff[5]) + 32'd1)
      else $error("draw did not increment the low word");

   a_write_low: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_operation == mwac_pkg::OP_WRITE && req_word_index == 3'd5
      |=> state_ff[5] == $past(req_data_value))
      else $error("word write lost");

   a_bad_read_zero: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_operation == mwac_pkg::OP_READ
      && (req_word_index == 3'd6 || req_word_index == 3'd7)
      |=> rsp_valid_ff && rsp_word_ff == '0)
      else $error("out-of-range read returned nonzero word");
`endif

endmodule

/* dv/multiword_add_carry_rng_core_tb.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the six-word add-with-carry generator
// Predicts every draw, seed, word write and word read from its own copy of
// the 192-bit state. Both handshakes get random stalls and a long response
// hold-off. Every response word is compared in order against its prediction.
// ----------------------------------------------------------------------------
module testbench;

   localparam int HOLD_CYCLES = 150;
   localparam int STALL_LIMIT = 1000;
   localparam int ITEM_TOTAL  = 650;
   localparam int QUIET_TAIL  = 120;
   localparam int DRAIN_GAP   = 8;

   class draw_scoreboard;
      mwac_pkg::word_type gen_words [0:5];
      mwac_pkg::word_type expected_words [$];
      int unsigned        failures;

      function new();
         for (int i = 0; i < 6; i++) gen_words[i] = mwac_pkg::SEED_BASE[i];
         failures = 0;
      endfunction

      // add chain with the inexact upper carries, then 192-bit increment
      function mwac_pkg::word_type draw_next();
         mwac_pkg::word_type n4, n3, n2, n1, n0;
         logic [32:0]        wide;
         wide = {1'b0, gen_words[5]} + {1'b0, gen_words[4]};
         n4 = wide[31:0];
         n3 = n4 + gen_words[3] + {31'd0, wide[32]};
         n2 = n3 + gen_words[2] + {31'd0, (n3 < n4)};
         n1 = n2 + gen_words[1] + {31'd0, (n2 < n3)};
         n0 = n1 + gen_words[0] + {31'd0, (n1 < n2)};
         gen_words[4] = n4;
         gen_words[3] = n3;
         gen_words[2] = n2;
         gen_words[1] = n1;
         gen_words[0] = n0;
         for (int k = 5; k >= 0; k--) begin
            gen_words[k] = gen_words[k] + 32'd1;
            if (k == 0) n0 = n0 + 32'd1;
            if (gen_words[k] != '0) break;
         end
         return n0;
      endfunction

      function void note_request(mwac_pkg::op_type op, mwac_pkg::word_type data,
                                 mwac_pkg::index_type idx);
         mwac_pkg::word_type result;
         result = '0;
         case (op)
            mwac_pkg::OP_DRAW: result = draw_next();
            mwac_pkg::OP_SEED: begin
               for (int i = 0; i < 6; i++) gen_words[i] = data + mwac_pkg::SEED_BASE[i];
            end
            mwac_pkg::OP_WRITE: begin
               if (idx < mwac_pkg::WORD_COUNT) gen_words[idx] = data;
            end
            default: begin
               if (idx < mwac_pkg::WORD_COUNT) result = gen_words[idx];
            end
         endcase
         expected_words.push_back(result);
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         failures++;
      endtask

      task check_word(mwac_pkg::word_type got);
         mwac_pkg::word_type want;
         if (expected_words.size() == 0) begin
            report($sformatf("result_word %h with nothing pending", got));
         end else begin
            want = expected_words.pop_front();
            if (got !== want)
               report($sformatf("result_word got %h expected %h", got, want));
         end
      endtask
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid;
   logic                req_ready;
   mwac_pkg::op_type    req_operation;
   mwac_pkg::word_type  req_data_value;
   mwac_pkg::index_type req_word_index;
   logic                rsp_valid;
   logic                rsp_ready;
   mwac_pkg::word_type  rsp_result_word;

   draw_scoreboard board = new();
   bit          idle_on = 1'b1;
   bit          hold_rsp = 1'b0;
   int unsigned items_sent = 0;
   int          quiet_cycles = 0;

   multiword_add_carry_rng_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_data_value  (req_data_value),
      .req_word_index  (req_word_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_word (rsp_result_word)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            board.note_request(req_operation, req_data_value, req_word_index);
         if (rsp_valid && rsp_ready)
            board.check_word(rsp_result_word);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      rsp_ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // holds the word until taken, returns at the following falling edge
   task automatic send_word(mwac_pkg::op_type op, mwac_pkg::word_type data,
                            mwac_pkg::index_type idx);
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_data_value <= data;
      req_word_index <= idx;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic go_quiet(int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic offer(mwac_pkg::op_type op, mwac_pkg::word_type data,
                        mwac_pkg::index_type idx);
      send_word(op, data, idx);
      items_sent++;
      if (idle_on && $urandom_range(0, 3) == 0) go_quiet($urandom_range(1, 13));
   endtask

   task automatic wait_results();
      go_quiet(1);
      while (board.expected_words.size() != 0) @(negedge clock);
   endtask

   function automatic mwac_pkg::word_type pick_data();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return $urandom();
      endcase
   endfunction

   // words 1..4 zero and word 5 all ones make the increment reach word 0
   task automatic ripple_draw(mwac_pkg::word_type top);
      offer(mwac_pkg::OP_WRITE, top, 3'd0);
      for (int k = 1; k < 5; k++) offer(mwac_pkg::OP_WRITE, '0, mwac_pkg::index_type'(k));
      offer(mwac_pkg::OP_WRITE, '1, 3'd5);
      offer(mwac_pkg::OP_DRAW, $urandom(), mwac_pkg::index_type'($urandom_range(0, 7)));
   endtask

   initial begin
      bit          held;
      bit          drained;
      int unsigned pick;
      req_valid      = 1'b0;
      req_operation  = mwac_pkg::OP_DRAW;
      req_data_value = '0;
      req_word_index = '0;
      held    = 1'b0;
      drained = 1'b0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      for (int k = 0; k < 8; k++) offer(mwac_pkg::OP_READ, '1, mwac_pkg::index_type'(k));
      offer(mwac_pkg::OP_DRAW, '0, 3'd0);
      offer(mwac_pkg::OP_DRAW, '1, 3'd7);
      offer(mwac_pkg::OP_WRITE, '1, mwac_pkg::WORD_COUNT);
      offer(mwac_pkg::OP_WRITE, '0, mwac_pkg::WORD_COUNT + 3'd1);
      ripple_draw('1);
      offer(mwac_pkg::OP_READ, '0, 3'd0);
      offer(mwac_pkg::OP_READ, '0, 3'd5);
      offer(mwac_pkg::OP_SEED, '0, 3'd0);
      offer(mwac_pkg::OP_DRAW, '0, 3'd0);
      offer(mwac_pkg::OP_SEED, '1, 3'd7);
      offer(mwac_pkg::OP_DRAW, '0, 3'd0);
      offer(mwac_pkg::OP_READ, '0, 3'd3);

      while (items_sent < ITEM_TOTAL) begin
         idle_on = (items_sent < ITEM_TOTAL - QUIET_TAIL) && ((items_sent / 60) % 4 != 3);
         if (!held && items_sent >= 250) begin
            held = 1'b1;
            hold_rsp = 1'b1;
            for (int k = 0; k < 20; k++)
               send_word(mwac_pkg::OP_DRAW, $urandom(),
                         mwac_pkg::index_type'($urandom_range(0, 7)));
            items_sent += 20;
         end
         if (!drained && items_sent >= 420) begin
            drained = 1'b1;
            wait_results();
         end
         pick = $urandom_range(0, 39);
         if (pick == 0)
            ripple_draw(pick_data());
         else if (pick < 20)
            offer(mwac_pkg::OP_DRAW, $urandom(), mwac_pkg::index_type'($urandom_range(0, 7)));
         else if (pick < 28)
            offer(mwac_pkg::OP_READ, $urandom(), mwac_pkg::index_type'($urandom_range(0, 7)));
         else if (pick < 36)
            offer(mwac_pkg::OP_WRITE, pick_data(), mwac_pkg::index_type'($urandom_range(0, 7)));
         else
            offer(mwac_pkg::OP_SEED, pick_data(), mwac_pkg::index_type'($urandom_range(0, 7)));
      end

      wait_results();
      repeat (DRAIN_GAP) @(posedge clock);
      if (board.failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
